/* hw/rtl/eps_pkg.sv */
// Shared types and constants for the EN/SET pulse programming sequencer.
// No dependencies; imported by every other RTL file of the block.
`default_nettype none

package eps_pkg;

    localparam int CUR_W   = 19;
    localparam int VOLT_W  = 23;
    localparam int HOLD_W  = 12;
    localparam int STEP_W  = 4;
    localparam int PULSE_W = 3;

    // charge current codes, 0.01 mA units
    localparam logic [CUR_W-1:0] CODE_100MA  = CUR_W'(10000);
    localparam logic [CUR_W-1:0] CODE_500MA  = CUR_W'(50000);
    localparam logic [CUR_W-1:0] CODE_850MA  = CUR_W'(85000);
    localparam logic [CUR_W-1:0] CODE_2300MA = CUR_W'(230000);
    localparam logic [CUR_W-1:0] CODE_0MA    = '0;

    localparam logic [VOLT_W-1:0] VOLT_HIGH = VOLT_W'(4350000);

    localparam logic [CUR_W-1:0]  REM_CUR_RST  = CUR_W'(8'hFF);
    localparam logic [VOLT_W-1:0] REM_VOLT_RST = VOLT_W'(8'hFF);

    // segment durations in us
    localparam logic [HOLD_W-1:0] HOLD_DISABLE = HOLD_W'(2100);
    localparam logic [HOLD_W-1:0] HOLD_FINAL   = HOLD_W'(1600);
    localparam logic [HOLD_W-1:0] HOLD_PULSE   = HOLD_W'(400);
    localparam logic [HOLD_W-1:0] HOLD_LEAD    = HOLD_W'(60);
    localparam logic [HOLD_W-1:0] HOLD_LEAD_LONG = HOLD_W'(100);
    localparam logic [HOLD_W-1:0] HOLD_VHIGH   = HOLD_W'(850);

    typedef enum logic {
        REG_CHARGE_CURRENT = 1'b0,
        REG_TARGET_VOLTAGE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_DISABLE = 2'd0,
        KIND_TRAIN   = 2'd1,
        KIND_ZERO    = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // what one request turns into; expanded segment by segment downstream
    typedef struct packed {
        t_kind              kind;
        logic [PULSE_W-1:0] pulses;
        logic               long_lead;
        logic               volt_high;
        logic               volt_level;
    } t_plan;

endpackage

`default_nettype wire

/* hw/rtl/enset_pulse_programming_sequencer_core.sv */
// Top level of the EN/SET pulse programming sequencer.
// Depends on eps_pkg, eps_req_decode and eps_seg_gen.
//
// Each input word is one enable request (tdata bit 0); each output word is
// one pin segment: level and hold time in us, with tlast on the final segment
// of a request. A disable gives one segment; an enable with changed settings
// gives from one to eleven; an enable with unchanged settings gives none.
// Segments leave at one per cycle while the output is taken, and the next
// request is taken in the cycle the last segment loads into the output
// register. Settings are written on the cfg channel, index 0 charge
// current, index 1 target voltage; it is always ready and must be
// written only while no segments are pending.
`default_nettype none

module enset_pulse_programming_sequencer_core
    import eps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_addr,
    input  wire logic [VOLT_W-1:0] i_cfg_data,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,   // [0] enable, [7:1] zero
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [15:0]            o_m_tdata,   // [0] pin_level, [12:1] hold_us, [15:13] zero
    output logic                   o_m_tlast
);

    t_plan             plan;
    logic              emit;
    logic              accept;
    logic              level;
    logic [HOLD_W-1:0] hold;
    t_reg_idx          cfg_addr;

    assign o_cfg_ready = 1'b1;
    assign cfg_addr    = t_reg_idx'(i_cfg_addr);
    assign accept      = i_s_tvalid && o_s_tready;

    eps_req_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_enable    (i_s_tdata[0]),
        .o_plan      (plan),
        .o_emit      (emit)
    );

    eps_seg_gen u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_plan  (plan),
        .i_emit  (emit),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_level (level),
        .o_hold  (hold),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, hold, level};

endmodule

`default_nettype wire

/* hw/rtl/eps_req_decode.sv */
// Settings registers, remembered state and request decode for the sequencer.
// Depends on eps_pkg.
`default_nettype none

module eps_req_decode
    import eps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire t_reg_idx          i_cfg_addr,
    input  wire logic [VOLT_W-1:0] i_cfg_data,
    input  wire logic              i_accept,
    input  wire logic              i_enable,
    output t_plan                  o_plan,
    output logic                   o_emit
);

    logic [CUR_W-1:0]  r_cur;
    logic [VOLT_W-1:0] r_volt;
    logic [CUR_W-1:0]  r_rem_cur;
    logic [VOLT_W-1:0] r_rem_volt;
    logic              r_driven;

    logic              changed;
    logic              lvl_after_cur;
    logic              n_driven;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_volt <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_CHARGE_CURRENT: r_cur  <= i_cfg_data[CUR_W-1:0];
                REG_TARGET_VOLTAGE: r_volt <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        changed          = (r_cur != r_rem_cur) || (r_volt != r_rem_volt);
        o_plan.pulses    = '0;
        o_plan.long_lead = 1'b0;
        o_plan.volt_high = (r_volt == VOLT_HIGH);
        lvl_after_cur    = r_driven;
        if (!i_enable) begin
            o_plan.kind = KIND_DISABLE;
        end else if (r_cur == CODE_100MA) begin
            o_plan.kind   = KIND_TRAIN;
            o_plan.pulses = PULSE_W'(2);
        end else if (r_cur == CODE_500MA) begin
            o_plan.kind   = KIND_TRAIN;
            o_plan.pulses = PULSE_W'(4);
        end else if (r_cur == CODE_850MA) begin
            o_plan.kind      = KIND_TRAIN;
            o_plan.pulses    = PULSE_W'(1);
            o_plan.long_lead = 1'b1;
        end else if (r_cur == CODE_2300MA) begin
            o_plan.kind   = KIND_TRAIN;
            o_plan.pulses = PULSE_W'(3);
        end else if (r_cur == CODE_0MA) begin
            o_plan.kind = KIND_ZERO;
        end else begin
            o_plan.kind = KIND_NONE;
        end
        // pulse trains end low, the 0 mA pattern ends high, unknown codes leave the pin
        if (o_plan.kind == KIND_TRAIN) begin
            lvl_after_cur = 1'b0;
        end else if (o_plan.kind == KIND_ZERO) begin
            lvl_after_cur = 1'b1;
        end
        o_plan.volt_level = lvl_after_cur;
        n_driven          = o_plan.volt_high ? 1'b0 : lvl_after_cur;
        o_emit            = !i_enable || changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_cur  <= REM_CUR_RST;
            r_rem_volt <= REM_VOLT_RST;
            r_driven   <= 1'b1;
        end else if (i_accept) begin
            if (!i_enable) begin
                r_rem_cur  <= '0;
                r_rem_volt <= '0;
                r_driven   <= 1'b1;
            end else if (changed) begin
                r_rem_cur  <= r_cur;
                r_rem_volt <= r_volt;
                r_driven   <= n_driven;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/eps_seg_gen.sv */
// Plan register, segment step counter and output register of the sequencer.
// Depends on eps_pkg.
`default_nettype none

module eps_seg_gen
    import eps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_plan             i_plan,
    input  wire logic              i_emit,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_level,
    output logic [HOLD_W-1:0]      o_hold,
    output logic                   o_last
);

    logic              r_busy;
    t_plan             r_plan;
    logic [STEP_W-1:0] r_step;
    logic              r_m_valid;
    logic              r_m_level;
    logic [HOLD_W-1:0] r_m_hold;
    logic              r_m_last;

    logic              advance;
    logic              accept;
    logic [STEP_W-1:0] cur_len;
    logic [STEP_W-1:0] total;
    logic [STEP_W-1:0] vstep;
    logic              seg_level;
    logic [HOLD_W-1:0] seg_hold;
    logic              seg_last;

    always_comb begin
        case (r_plan.kind)
            KIND_TRAIN: cur_len = {r_plan.pulses, 1'b1};
            KIND_ZERO:  cur_len = STEP_W'(1);
            default:    cur_len = '0;
        endcase
        total = cur_len + (r_plan.volt_high ? STEP_W'(2) : STEP_W'(1));
        vstep = r_step - cur_len;

        if (r_plan.kind == KIND_DISABLE) begin
            seg_level = 1'b1;
            seg_hold  = HOLD_DISABLE;
            seg_last  = 1'b1;
        end else begin
            seg_last = (r_step == total - STEP_W'(1));
            if (r_step < cur_len) begin
                if (r_plan.kind == KIND_ZERO) begin
                    seg_level = 1'b1;
                    seg_hold  = HOLD_FINAL;
                end else if (r_step == '0) begin
                    seg_level = 1'b0;
                    seg_hold  = r_plan.long_lead ? HOLD_LEAD_LONG : HOLD_LEAD;
                end else if (r_step[0]) begin
                    seg_level = 1'b1;
                    seg_hold  = HOLD_PULSE;
                end else begin
                    seg_level = 1'b0;
                    seg_hold  = (r_step == cur_len - STEP_W'(1)) ? HOLD_FINAL : HOLD_PULSE;
                end
            end else if (r_plan.volt_high) begin
                seg_level = vstep[0] ? 1'b0 : 1'b1;
                seg_hold  = vstep[0] ? HOLD_FINAL : HOLD_VHIGH;
            end else begin
                seg_level = r_plan.volt_level;
                seg_hold  = HOLD_FINAL;
            end
        end
    end

    // output register frees each cycle it is empty or being taken
    assign advance = !r_m_valid || i_ready;
    assign o_ready = !r_busy || (advance && seg_last);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_m_valid <= 1'b0;
            r_step    <= '0;
        end else begin
            if (advance) begin
                r_m_valid <= r_busy;
                r_step    <= r_step + STEP_W'(1);
            end
            if (accept) begin
                r_busy <= i_emit;
                r_step <= '0;
            end else if (advance && seg_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plan <= i_plan;
        end
        if (advance && r_busy) begin
            r_m_level <= seg_level;
            r_m_hold  <= seg_hold;
            r_m_last  <= seg_last;
        end
    end

    assign o_valid = r_m_valid;
    assign o_level = r_m_level;
    assign o_hold  = r_m_hold;
    assign o_last  = r_m_last;

endmodule

`default_nettype wire

/* sim/eps_seg_checker.sv */
// Segment checker for the EN/SET pulse programming sequencer: watches the cfg,
// request and segment channels, predicts each segment and compares it.
// Depends on eps_pkg for widths, current codes and hold times.

module eps_seg_checker
    import eps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic              i_cfg_addr,
    input  wire logic [VOLT_W-1:0] i_cfg_data,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [7:0]        i_s_tdata,
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [15:0]       i_m_tdata,
    input  wire logic              i_m_tlast,
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct packed {
        logic              level;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } t_seg_word;

    t_seg_word          seg_q[$];
    logic [CUR_W-1:0]   cfg_cur;
    logic [VOLT_W-1:0]  cfg_volt;
    logic [CUR_W-1:0]   rem_cur;
    logic [VOLT_W-1:0]  rem_volt;
    logic               pin_now;
    int                 mismatches = 0;

    task automatic push_seg(input logic lvl, input logic [HOLD_W-1:0] hold);
        seg_q.push_back('{level: lvl, hold_us: hold, last: 1'b0});
        pin_now = lvl;
    endtask

    // lead low, then n pulses; the low after the final pulse is the long one
    task automatic push_train(input logic [HOLD_W-1:0] lead, input int pulses);
        push_seg(1'b0, lead);
        for (int k = 1; k <= pulses; k++) begin
            push_seg(1'b1, HOLD_PULSE);
            push_seg(1'b0, (k == pulses) ? HOLD_FINAL : HOLD_PULSE);
        end
    endtask

    task automatic predict_segments(input logic en);
        int        base;
        t_seg_word tail;
        base = seg_q.size();
        if (!en) begin
            push_seg(1'b1, HOLD_DISABLE);
            rem_cur  = '0;
            rem_volt = '0;
        end else if (cfg_cur != rem_cur || cfg_volt != rem_volt) begin
            case (cfg_cur)
                CODE_100MA:  push_train(HOLD_LEAD, 2);
                CODE_500MA:  push_train(HOLD_LEAD, 4);
                CODE_850MA:  push_train(HOLD_LEAD_LONG, 1);
                CODE_2300MA: push_train(HOLD_LEAD, 3);
                CODE_0MA:    push_seg(1'b1, HOLD_FINAL);
                default: ;   // unknown code: voltage part only
            endcase
            if (cfg_volt == VOLT_HIGH) begin
                push_seg(1'b1, HOLD_VHIGH);
                push_seg(1'b0, HOLD_FINAL);
            end else begin
                push_seg(pin_now, HOLD_FINAL);
            end
            rem_cur  = cfg_cur;
            rem_volt = cfg_volt;
        end
        if (seg_q.size() > base) begin
            tail      = seg_q.pop_back();
            tail.last = 1'b1;
            seg_q.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_seg_word want;
        logic      got_level;
        logic [HOLD_W-1:0] got_hold;
        if (!i_rst_n) begin
            cfg_cur  = '0;
            cfg_volt = '0;
            rem_cur  = REM_CUR_RST;
            rem_volt = REM_VOLT_RST;
            pin_now  = 1'b1;
            seg_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_level = i_m_tdata[0];
                got_hold  = i_m_tdata[HOLD_W:1];
                if (seg_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected segment level=%0d hold=%0d last=%0d",
                                 $realtime, got_level, got_hold, i_m_tlast);
                    mismatches++;
                end else begin
                    want = seg_q.pop_front();
                    if (want.level !== got_level || want.hold_us !== got_hold ||
                        want.last !== i_m_tlast) begin
                        if (mismatches < 10)
                            $display("%0t: exp lvl=%0d hold=%0d last=%0d, got %0d %0d %0d",
                                     $realtime, want.level, want.hold_us, want.last,
                                     got_level, got_hold, i_m_tlast);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_segments(i_s_tdata[0]);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_addr == REG_CHARGE_CURRENT)
                    cfg_cur = i_cfg_data[CUR_W-1:0];
                else
                    cfg_volt = i_cfg_data;
            end
        end
        o_pending    <= seg_q.size();
        o_mismatches <= mismatches;
    end

endmodule

/* sim/tb.sv */
// Testbench top for enset_pulse_programming_sequencer_core: drives settings and
// enable requests under varying idle/stall patterns and gives the verdict.
// Depends on eps_pkg, the block RTL and eps_seg_checker.

module tb;
    import eps_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int PHASE_ITEMS   = 88;
    localparam int WR_BOTH = 0;
    localparam int WR_CUR  = 1;
    localparam int WR_VOLT = 2;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_addr  = 1'b0;
    logic [VOLT_W-1:0] i_cfg_data  = '0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata   = '0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [15:0]       o_m_tdata;
    logic              o_m_tlast;

    int chk_fail;
    int chk_pending;
    int cycle_cnt  = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_asked = 0;
    int hold_seen  = 0;

    enset_pulse_programming_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    eps_seg_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (chk_fail),
        .o_pending    (chk_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // segment sink: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays high on return; next call either reuses it or drops it
    task automatic send_request(input logic en);
        if ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, en};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        // a request with no segments may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [VOLT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [VOLT_W-1:0] cur_word,
                                 input logic [VOLT_W-1:0] volt_word, input int which);
        drain();
        if (which != WR_VOLT)
            write_reg(REG_CHARGE_CURRENT, cur_word);
        if (which != WR_CUR)
            write_reg(REG_TARGET_VOLTAGE, volt_word);
        i_cfg_valid <= 1'b0;
    endtask

    // upper four bits are beyond the current register and must be dropped
    function automatic logic [VOLT_W-1:0] pick_current();
        logic [CUR_W-1:0] c;
        case ($urandom_range(9))
            0, 1: c = CODE_100MA;
            2, 3: c = CODE_500MA;
            4:    c = CODE_850MA;
            5:    c = CODE_2300MA;
            6:    c = CODE_0MA;
            7:    c = CODE_500MA + CUR_W'($urandom_range(1, 3));
            8:    c = ($urandom_range(1) != 0) ? '1 : CUR_W'(300000);
            default: c = CUR_W'($urandom);
        endcase
        return {4'($urandom), c};
    endfunction

    function automatic logic [VOLT_W-1:0] pick_voltage();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return VOLT_HIGH;
            5:    return '0;
            6:    return '1;
            7:    return VOLT_HIGH + VOLT_W'(1);
            default: return VOLT_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            apply_setting(pick_current(), pick_voltage(), $urandom_range(2));
            burst = $urandom_range(3, 12);
            repeat (burst) begin
                send_request($urandom_range(99) < 65);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // settings equal to the reset-time memory: enable gives nothing
        apply_setting(VOLT_W'(REM_CUR_RST), REM_VOLT_RST, WR_BOTH);
        send_request(1'b1);
        // zero current, plain voltage; repeated enable and repeated disable
        apply_setting('0, '0, WR_BOTH);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        apply_setting(VOLT_W'(CODE_100MA), VOLT_HIGH, WR_BOTH);
        send_request(1'b1);
        send_request(1'b1);
        apply_setting(VOLT_W'(CODE_500MA), VOLT_HIGH, WR_CUR);
        send_request(1'b1);
        apply_setting(VOLT_W'(CODE_850MA), '0, WR_BOTH);
        send_request(1'b1);
        apply_setting(VOLT_W'(CODE_2300MA), VOLT_W'(5000000), WR_BOTH);
        send_request(1'b1);
        send_request(1'b0);
        apply_setting(VOLT_W'(CODE_0MA), VOLT_HIGH, WR_BOTH);
        send_request(1'b1);
        // unknown code after a low-ending pattern keeps the pin low
        apply_setting(VOLT_W'(12345), VOLT_W'(3000000), WR_BOTH);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        apply_setting('1, '1, WR_BOTH);
        send_request(1'b1);
        apply_setting({4'hA, CODE_100MA}, VOLT_HIGH, WR_CUR);
        send_request(1'b1);
        apply_setting({4'h5, CODE_2300MA}, '0, WR_CUR);
        send_request(1'b1);

        // no idling, with one long sink hold-off while requests keep coming
        idle_pct  = 0;
        stall_pct = 0;
        random_phase(PHASE_ITEMS / 2);
        apply_setting(VOLT_W'(CODE_500MA), VOLT_HIGH, WR_BOTH);
        hold_asked++;
        for (int k = 0; k < 30; k++)
            send_request(k[0]);
        drain();
        random_phase(PHASE_ITEMS / 2);

        idle_pct  = 86;
        stall_pct = 0;
        random_phase(PHASE_ITEMS);
        idle_pct  = 0;
        stall_pct = 86;
        random_phase(PHASE_ITEMS);
        idle_pct  = 19;
        stall_pct = 19;
        random_phase(PHASE_ITEMS);

        drain();
        if (chk_pending != 0)
            $display("%0d segments never arrived", chk_pending);
        if (chk_fail == 0 && chk_pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
